// ===== rtl/wef_pkg.sv =====
// Package for the wheel emulation filter: beat types, configuration layout,
// controller states and command/status structs.
// No dependencies.
package wef_pkg;

    // Highest valid button number
    localparam logic [5:0] MAX_BUTTONS = 6'd32;

    // Divider: 17-bit dividend, one quotient bit per step
    localparam int DIV_STEPS = 17;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    // Configuration reset values
    localparam logic        RST_WHEEL_ENABLE = 1'b0;
    localparam logic [5:0]  RST_WHEEL_BUTTON = 6'd4;
    localparam logic [15:0] RST_INERTIA      = 16'd10;
    localparam logic [15:0] RST_TIMEOUT_MS   = 16'd200;
    localparam logic [5:0]  RST_X_NEG_BUTTON = 6'd0;
    localparam logic [5:0]  RST_X_POS_BUTTON = 6'd0;
    localparam logic [5:0]  RST_Y_NEG_BUTTON = 6'd4;
    localparam logic [5:0]  RST_Y_POS_BUTTON = 6'd5;

    // Event opcodes
    localparam logic OP_BUTTON = 1'b0;
    localparam logic OP_MOTION = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_WHEEL_ENABLE = 3'd0,
        CFG_WHEEL_BUTTON = 3'd1,
        CFG_INERTIA      = 3'd2,
        CFG_TIMEOUT_MS   = 3'd3,
        CFG_X_NEG_BUTTON = 3'd4,
        CFG_X_POS_BUTTON = 3'd5,
        CFG_Y_NEG_BUTTON = 3'd6,
        CFG_Y_POS_BUTTON = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        wheel_enable;
        logic [5:0]  wheel_button;
        logic [15:0] inertia;
        logic [15:0] timeout_ms;
        logic [5:0]  x_negative_button;
        logic [5:0]  x_positive_button;
        logic [5:0]  y_negative_button;
        logic [5:0]  y_positive_button;
    } t_cfg;

    // Input beat
    typedef struct packed {
        logic               opcode;
        logic [5:0]         event_button;
        logic               pressed;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [31:0]        now_ms;
    } t_in_item;

    // Output beat
    typedef struct packed {
        logic        consumed;
        logic [5:0]  click_button;
        logic [16:0] click_count;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic finish;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic travel;
    } t_dp_status;

endpackage

// ===== rtl/wef_cfg.sv =====
// Configuration register file of the wheel emulation filter.
// Depends on wef_pkg.
module wef_cfg
    import wef_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_btn_ok;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign w_btn_ok    = (i_cfg_data[5:0] <= MAX_BUTTONS);

    // Register write decode; bad values leave the register as it was
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WHEEL_ENABLE: n_cfg.wheel_enable = i_cfg_data[0];
                CFG_WHEEL_BUTTON: if (w_btn_ok) n_cfg.wheel_button = i_cfg_data[5:0];
                CFG_INERTIA:      if (i_cfg_data != '0) n_cfg.inertia = i_cfg_data;
                CFG_TIMEOUT_MS:   n_cfg.timeout_ms = i_cfg_data;
                CFG_X_NEG_BUTTON: if (w_btn_ok) n_cfg.x_negative_button = i_cfg_data[5:0];
                CFG_X_POS_BUTTON: if (w_btn_ok) n_cfg.x_positive_button = i_cfg_data[5:0];
                CFG_Y_NEG_BUTTON: if (w_btn_ok) n_cfg.y_negative_button = i_cfg_data[5:0];
                CFG_Y_POS_BUTTON: if (w_btn_ok) n_cfg.y_positive_button = i_cfg_data[5:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_enable      <= RST_WHEEL_ENABLE;
            r_cfg.wheel_button      <= RST_WHEEL_BUTTON;
            r_cfg.inertia           <= RST_INERTIA;
            r_cfg.timeout_ms        <= RST_TIMEOUT_MS;
            r_cfg.x_negative_button <= RST_X_NEG_BUTTON;
            r_cfg.x_positive_button <= RST_X_POS_BUTTON;
            r_cfg.y_negative_button <= RST_Y_NEG_BUTTON;
            r_cfg.y_positive_button <= RST_Y_POS_BUTTON;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Divider relies on a nonzero divisor
    a_inertia_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.inertia != '0)
        else $error("inertia register holds zero");

endmodule

// ===== rtl/wef_ctrl.sv =====
// Controller state machine of the wheel emulation filter: sequences load,
// evaluate, divide, finish and emit; owns the handshakes.
// Depends on wef_pkg.
module wef_ctrl
    import wef_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;

    assign o_out_valid = r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.travel) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EVAL))
        else $error("accepted beat not followed by evaluation");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider step count out of range");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output state");

endmodule

// ===== rtl/wef_dp.sv =====
// Datapath of the wheel emulation filter: event evaluation, held/expiry and
// axis distance state, restoring divider, result and output registers.
// Depends on wef_pkg.
module wef_dp
    import wef_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_in_item   i_in_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_out_item
);

    // Filter state
    logic               r_held,   n_held;
    logic [31:0]        r_expiry, n_expiry;
    logic signed [17:0] r_xdist,  n_xdist;
    logic signed [17:0] r_ydist,  n_ydist;

    // Working registers
    t_in_item    r_in;
    t_out_item   r_res, n_res;
    t_out_item   r_out;
    logic        r_axis_y;
    logic [17:0] r_d;
    logic [5:0]  r_neg_btn, r_pos_btn;
    logic [15:0] r_rem, n_rem;
    logic [16:0] r_quo, n_quo;

    // Evaluation terms
    logic [31:0] w_diff;
    logic        w_not_expired;
    logic        w_dx_nz;
    logic        w_dy_nz;
    logic [15:0] w_value;
    logic [17:0] w_dist;
    logic [17:0] w_d;
    logic [17:0] w_neg_d;
    logic [16:0] w_mag;
    logic [16:0] w_dividend;
    logic [5:0]  w_neg_btn, w_pos_btn;
    logic        w_travel;
    t_out_item   w_eval_res;
    logic        w_eval_held;
    logic [31:0] w_eval_expiry;

    // Divider and finish terms
    logic [16:0] w_trial;
    logic [16:0] w_trial_sub;
    logic        w_ge;
    logic [17:0] w_rem1;
    logic [17:0] w_rem1_neg;
    logic [17:0] w_new_d;

    assign o_out_item = r_out;

    // Timer and axis selection
    always_comb begin
        w_diff        = r_expiry - r_in.now_ms;
        w_not_expired = (w_diff != '0) && !w_diff[31];
        w_dx_nz       = (r_in.delta_x != '0);
        w_dy_nz       = (r_in.delta_y != '0);
        w_value       = w_dx_nz ? r_in.delta_x : r_in.delta_y;
        w_dist        = w_dx_nz ? r_xdist : r_ydist;
        w_neg_btn     = w_dx_nz ? i_cfg.x_negative_button : i_cfg.y_negative_button;
        w_pos_btn     = w_dx_nz ? i_cfg.x_positive_button : i_cfg.y_positive_button;
        w_d           = w_dist + {{2{w_value[15]}}, w_value};
        w_neg_d       = -w_d;
        w_mag         = w_d[17] ? w_neg_d[16:0] : w_d[16:0];
        w_dividend    = (w_mag == '0) ? '0 : (w_mag - 17'd1);
    end

    // Event decision
    always_comb begin
        w_eval_res    = '0;
        w_eval_held   = r_held;
        w_eval_expiry = r_expiry;
        w_travel      = 1'b0;
        if (i_cfg.wheel_enable) begin
            if (r_in.opcode == OP_BUTTON) begin
                if (r_in.event_button == i_cfg.wheel_button) begin
                    w_eval_res.consumed = 1'b1;
                    w_eval_held         = r_in.pressed;
                    if (r_in.pressed) begin
                        w_eval_expiry = r_in.now_ms + {16'd0, i_cfg.timeout_ms};
                    end else if (w_not_expired) begin
                        w_eval_res.click_button = r_in.event_button;
                        w_eval_res.click_count  = 17'd1;
                    end
                end
            end else if (r_held || (i_cfg.wheel_button == '0)) begin
                if ((i_cfg.wheel_button != '0) && w_not_expired) begin
                    w_eval_res.consumed = 1'b1;
                end else if (w_dx_nz || w_dy_nz) begin
                    w_eval_res.consumed = 1'b1;
                    w_travel            = (w_neg_btn != '0);
                end
            end
        end
    end

    assign o_status.travel = w_travel;

    // Restoring divide step: one quotient bit per cycle
    always_comb begin
        w_trial     = {r_rem, r_quo[16]};
        w_ge        = (w_trial >= {1'b0, i_cfg.inertia});
        w_trial_sub = w_trial - {1'b0, i_cfg.inertia};
    end

    // Remaining travel after clicks: sign of d with magnitude remainder + 1; d unchanged when no click
    always_comb begin
        w_rem1     = {2'b00, r_rem} + 18'd1;
        w_rem1_neg = -w_rem1;
        if (r_quo == '0) begin
            w_new_d = r_d;
        end else begin
            w_new_d = r_d[17] ? w_rem1_neg : w_rem1;
        end
    end

    // Next values of state and working registers
    always_comb begin
        n_held   = r_held;
        n_expiry = r_expiry;
        n_xdist  = r_xdist;
        n_ydist  = r_ydist;
        n_res    = r_res;
        n_rem    = r_rem;
        n_quo    = r_quo;
        if (i_cmd.eval) begin
            n_held   = w_eval_held;
            n_expiry = w_eval_expiry;
            n_res    = w_eval_res;
            n_rem    = '0;
            n_quo    = w_dividend;
        end
        if (i_cmd.div_step) begin
            n_rem = w_ge ? w_trial_sub[15:0] : w_trial[15:0];
            n_quo = {r_quo[15:0], w_ge};
        end
        if (i_cmd.finish) begin
            if (r_axis_y) begin
                n_ydist = w_new_d;
                if (r_quo != '0) n_xdist = '0;
            end else begin
                n_xdist = w_new_d;
                if (r_quo != '0) n_ydist = '0;
            end
            if (r_quo != '0) begin
                n_res.click_count  = r_quo;
                n_res.click_button = r_d[17] ? r_neg_btn : r_pos_btn;
            end
        end
    end

    // Filter state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 1'b0;
            r_expiry <= '0;
            r_xdist  <= '0;
            r_ydist  <= '0;
        end else begin
            r_held   <= n_held;
            r_expiry <= n_expiry;
            r_xdist  <= n_xdist;
            r_ydist  <= n_ydist;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_cmd.load) begin
            r_in <= i_in_item;
        end
        if (i_cmd.eval) begin
            r_axis_y  <= !w_dx_nz;
            r_d       <= w_d;
            r_neg_btn <= w_neg_btn;
            r_pos_btn <= w_pos_btn;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    a_no_click_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out.click_count != '0 || r_out.click_button == '0))
        else $error("button reported without clicks");

    a_clicks_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out.consumed || r_out.click_count == '0))
        else $error("clicks reported on an event passed on");

endmodule

// ===== rtl/wheel_emulation_filter_core.sv =====
// Wheel emulation filter: turns pointer button and motion events into
// emulated wheel clicks.
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in_item) carries one
//   event beat: opcode, button, press flag, dx, dy and the millisecond time.
//   Output channel (o_out_valid / i_out_stall, payload o_out_item) returns
//   exactly one beat per event: consumed flag, click button, click count.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
//   i_cfg_data) writes the eight registers; write only while idle.
// Timing:
//   Button events and motion that needs no travel go from evaluation
//   straight to output. Motion on an axis with a nonzero negative button
//   runs the distance through a 17-step restoring divider by inertia, then
//   a finish step. One event is in work at a time; no new event is taken
//   until the current one has been emitted.
// Stall and reset:
//   A finished beat waits in the output register while the receiver
//   stalls; the next event may be taken meanwhile but is not emitted until
//   that beat leaves. Synchronous reset clears the held flag, the expiry
//   time, both distances and the output valid, and loads the register
//   defaults.
// Depends on wef_pkg, wef_cfg, wef_ctrl, wef_dp.
module wheel_emulation_filter_core
    import wef_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_cfg_wr;

    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;

    // Register file
    wef_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (w_cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // Sequencer
    wef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath
    wef_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_item (o_out_item)
    );

endmodule
